>>> src/dpd_pkg.sv
// Package with shared types, codes and a helper for the debug packet deframer.
`default_nettype none
package dpd_pkg;

	// Parser phase codes.
	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_CONTENT = 3'd1,
		PH_DIGIT0  = 3'd2,
		PH_DIGIT1  = 3'd3,
		PH_DONE    = 3'd4
	} dpd_phase_t;

	// Report status codes.
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_MISMATCH = 3'd1,
		ST_BADHEX   = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_NOSTART  = 3'd4,
		ST_TRUNC    = 3'd5
	} dpd_status_t;

	// Input item kind carried on tuser.
	localparam logic OP_DATA = 1'b0;
	localparam logic OP_EOS  = 1'b1;

	// Result kind carried on tlast.
	localparam logic KIND_BYTE   = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	// Register indexes of the configuration port.
	localparam logic REG_START_CHAR = 1'b0;
	localparam logic REG_CHECK_CHAR = 1'b1;

	localparam logic [7:0] START_CHAR_RESET = 8'd36;
	localparam logic [7:0] CHECK_CHAR_RESET = 8'd35;

	// Width of the packed result data word.
	localparam int unsigned OUT_DATA_W = 32;

	// Per-packet parser state.
	typedef struct packed {
		dpd_phase_t phase;
		logic [7:0] running_sum;
		logic       seen_content;
		logic [3:0] high_nibble;
		logic       hex_error;
	} dpd_state_t;

	// One result item with its valid flag.
	typedef struct packed {
		logic        valid;
		logic        kind;
		logic [7:0]  data_byte;
		logic [7:0]  received_sum;
		logic [7:0]  computed_sum;
		dpd_status_t status;
	} dpd_result_t;

	// Hex digit value; ok is the high bit of the result.
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c inside {["0":"9"]}) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c inside {["a":"f"]}) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c inside {["A":"F"]}) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> src/debug_packet_deframer_checksum.sv
// Top level of the debug packet deframer with checksum check.
//
// Input stream: one character per transaction on s_tdata; s_tuser high marks
// the end of a string (the data byte is then ignored). Bytes before the start
// character are dropped. Each content byte is echoed on the output stream with
// m_tlast low; the end-of-packet report has m_tlast high and carries the
// received and computed checksums and a status code.
// The result of an accepted byte is in the output register at the next clock
// edge. One byte is accepted every cycle; the only limit is the single output
// register, which takes a new result when it is empty or is being drained in
// the same cycle.
// If the receiver stalls, m_tvalid and m_tdata hold and s_tready follows
// m_tready once the register is full; bytes that give no result still wait.
// Reset puts the parser in the hunting phase, clears the output valid flag and
// restores the start and check characters to their defaults.
// Configuration writes (cfg_we) take effect at the next clock edge. The user
// must make them only while the block is idle; it does not enforce this.
`default_nettype none
module debug_packet_deframer_checksum (
	input  wire        clk,
	input  wire        arst_n,
	// Configuration write port.
	input  wire        cfg_we,
	input  wire        cfg_index,
	input  wire [7:0]  cfg_data,
	// Input stream.
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [7:0]  s_tdata,  // [7:0] in_byte
	input  wire        s_tuser,  // [0] opcode
	// Output stream.
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [dpd_pkg::OUT_DATA_W-1:0] m_tdata,
	// [7:0] data_byte, [15:8] received_sum, [23:16] computed_sum,
	// [26:24] status, [31:27] zero
	output logic       m_tlast   // result_kind
);

	logic [7:0]           start_q;
	logic [7:0]           check_q;
	dpd_pkg::dpd_state_t  state_q;
	dpd_pkg::dpd_state_t  state_nxt;
	dpd_pkg::dpd_result_t res;
	logic                 accept;
	logic                 out_valid_q;
	logic                 kind_q;
	logic [7:0]           data_q;
	logic [7:0]           rx_q;
	logic [7:0]           calc_q;
	dpd_pkg::dpd_status_t status_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= dpd_pkg::START_CHAR_RESET;
			check_q <= dpd_pkg::CHECK_CHAR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				dpd_pkg::REG_START_CHAR: start_q <= cfg_data;
				dpd_pkg::REG_CHECK_CHAR: check_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Accept when the output register is free or drains this cycle.
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	dpd_parser u_parser (
		.opcode     (s_tuser),
		.in_byte    (s_tdata),
		.start_char (start_q),
		.check_char (check_q),
		.cur        (state_q),
		.nxt        (state_nxt),
		.res        (res)
	);

	// Parser state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= {dpd_pkg::PH_HUNT, 8'd0, 1'b0, 4'd0, 1'b0};
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (accept && res.valid) begin
			kind_q   <= res.kind;
			data_q   <= res.data_byte;
			rx_q     <= res.received_sum;
			calc_q   <= res.computed_sum;
			status_q <= res.status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = kind_q;
	assign m_tdata  = {5'd0, status_q, calc_q, rx_q, data_q};

	// An accepted end of string always returns the parser to hunting.
	a_eos_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tuser |=> state_q.phase == dpd_pkg::PH_HUNT)
		else $error("parser not hunting after end of string");

	// An ok report carries equal checksums.
	a_ok_equal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast && status_q == dpd_pkg::ST_OK |-> rx_q == calc_q)
		else $error("ok status with differing checksums");

	// An echoed content byte carries zero report fields.
	a_byte_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[26:8] == '0)
		else $error("content byte with nonzero report fields");

	// A finished packet's report is not followed by echoed content.
	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res.valid && res.kind && state_nxt.phase == dpd_pkg::PH_DONE
		|=> !(accept && res.valid && !res.kind))
		else $error("content echoed after packet end");

	// An empty output register never blocks the input.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output register");

endmodule
`default_nettype wire

>>> src/dpd_parser.sv
// Next-state and result logic of the packet parser for one input byte.
`default_nettype none
module dpd_parser (
	input  wire                 opcode,
	input  wire [7:0]           in_byte,
	input  wire [7:0]           start_char,
	input  wire [7:0]           check_char,
	input  wire dpd_pkg::dpd_state_t cur,
	output dpd_pkg::dpd_state_t nxt,
	output dpd_pkg::dpd_result_t res
);

	logic [4:0] hex;
	logic [7:0] rx_sum;
	logic       err;
	logic [7:0] sum_add;

	assign hex     = dpd_pkg::hex_decode(in_byte);
	assign rx_sum  = {cur.high_nibble, hex[3:0]};
	assign err     = cur.hex_error | ~hex[4];
	assign sum_add = cur.running_sum + in_byte;

	// Phase transitions and the single possible result.
	always_comb begin
		nxt = cur;
		res = '0;
		res.status = dpd_pkg::ST_OK;
		if (opcode == dpd_pkg::OP_EOS) begin
			// End of string: report unless a packet already finished.
			nxt = '0;
			nxt.phase = dpd_pkg::PH_HUNT;
			case (cur.phase)
				dpd_pkg::PH_HUNT: begin
					res.valid  = 1'b1;
					res.kind   = dpd_pkg::KIND_REPORT;
					res.status = dpd_pkg::ST_NOSTART;
				end
				dpd_pkg::PH_CONTENT, dpd_pkg::PH_DIGIT0, dpd_pkg::PH_DIGIT1: begin
					res.valid        = 1'b1;
					res.kind         = dpd_pkg::KIND_REPORT;
					res.computed_sum = cur.running_sum;
					res.status       = dpd_pkg::ST_TRUNC;
				end
				default: begin
				end
			endcase
		end else begin
			case (cur.phase)
				dpd_pkg::PH_HUNT: begin
					if (in_byte == start_char) begin
						nxt = '0;
						nxt.phase = dpd_pkg::PH_CONTENT;
					end
				end
				dpd_pkg::PH_CONTENT: begin
					if (in_byte == check_char) begin
						if (!cur.seen_content) begin
							res.valid  = 1'b1;
							res.kind   = dpd_pkg::KIND_REPORT;
							res.status = dpd_pkg::ST_EMPTY;
							nxt.phase  = dpd_pkg::PH_DONE;
						end else begin
							nxt.phase = dpd_pkg::PH_DIGIT0;
						end
					end else begin
						// Echo the content byte and fold it into the sum.
						nxt.running_sum  = sum_add;
						nxt.seen_content = 1'b1;
						res.valid        = 1'b1;
						res.kind         = dpd_pkg::KIND_BYTE;
						res.data_byte    = in_byte;
					end
				end
				dpd_pkg::PH_DIGIT0: begin
					nxt.high_nibble = hex[3:0];
					nxt.hex_error   = err;
					nxt.phase       = dpd_pkg::PH_DIGIT1;
				end
				dpd_pkg::PH_DIGIT1: begin
					// Last checksum digit closes the packet.
					nxt.hex_error    = err;
					nxt.phase        = dpd_pkg::PH_DONE;
					res.valid        = 1'b1;
					res.kind         = dpd_pkg::KIND_REPORT;
					res.received_sum = rx_sum;
					res.computed_sum = cur.running_sum;
					if (err) begin
						res.status = dpd_pkg::ST_BADHEX;
					end else if (rx_sum == cur.running_sum) begin
						res.status = dpd_pkg::ST_OK;
					end else begin
						res.status = dpd_pkg::ST_MISMATCH;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire
